// File: sv/assert_macros.svh
// assertion macros for the stack rtl
// no dependencies; included by lsd_ctrl, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication from one edge to the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lsd_pkg.sv
// types and constants of the lifo stack with dump
// no dependencies; used by the interfaces and every module
package lsd_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    // the operation that every cell of the chain carries out
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP,
        SH_ROT
    } t_shift;

endpackage

// File: sv/lsd_ifs.sv
// valid/ready channels for commands and results
// depends on lsd_pkg
interface lsd_in_if;
    import lsd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface lsd_out_if;
    import lsd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word;
    logic [STAT_W-1:0]        status;
    logic                     last;

    modport source (output valid, output word, output status, output last, input ready);
    modport sink   (input valid, input word, input status, input last, output ready);
endinterface

// File: sv/lsd_cell.sv
// one storage cell of the stack chain; cell 0 is the top
// depends on lsd_pkg
module lsd_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 7
) (
    input  logic                             i_clk,
    input  lsd_pkg::t_shift                  i_op,
    input  logic [FILL_W-1:0]                i_fill,
    input  logic signed [lsd_pkg::WORD_W-1:0] i_up,
    input  logic signed [lsd_pkg::WORD_W-1:0] i_down,
    input  logic signed [lsd_pkg::WORD_W-1:0] i_top,
    output logic signed [lsd_pkg::WORD_W-1:0] o_word
);
    import lsd_pkg::*;

    localparam logic [FILL_W-1:0] POS = FILL_W'(IDX + 1);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_op)
            SH_PUSH: n_word = i_up;
            SH_POP:  n_word = i_down;
            SH_ROT: begin
                // the lowest occupied cell takes the old top word
                if (POS == i_fill) begin
                    n_word = i_top;
                end else if (POS < i_fill) begin
                    n_word = i_down;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: sv/lsd_ctrl.sv
// command decode, fill count, dump walk and result register
// depends on lsd_pkg, lsd_ifs and assert_macros.svh
module lsd_ctrl #(
    parameter int DEPTH  = 64,
    parameter int FILL_W = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lsd_in_if.sink                           i_cmd,
    lsd_out_if.source                        o_res,
    input  logic signed [lsd_pkg::WORD_W-1:0] i_top,
    output lsd_pkg::t_shift                  o_op,
    output logic [FILL_W-1:0]                o_fill
);
    import lsd_pkg::*;
    `include "assert_macros.svh"

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] ONE      = FILL_W'(1);

    t_state r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_left, n_left;
    logic                     r_out_valid, n_out_valid;
    logic signed [WORD_W-1:0] r_word, n_word;
    logic [STAT_W-1:0]        r_status, n_status;
    logic                     r_last, n_last;

    logic   slot_free;
    logic   accept;
    t_shift op;

    assign slot_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && slot_free;
    assign accept = i_cmd.valid && i_cmd.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.command == CMD_DISPLAY && r_fill != '0) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (slot_free && r_left == ONE) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op          = SH_HOLD;
        n_fill      = r_fill;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_res.ready;
        n_word      = r_word;
        n_status    = r_status;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.command)
                        CMD_PUSH: begin
                            n_out_valid = 1'b1;
                            n_word      = i_cmd.push_value;
                            n_last      = 1'b1;
                            if (r_fill == FILL_MAX) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_status = STAT_OK;
                                op       = SH_PUSH;
                                n_fill   = r_fill + ONE;
                            end
                        end
                        CMD_POP: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            if (r_fill == '0) begin
                                n_word   = EMPTY_WORD;
                                n_status = STAT_EMPTY;
                            end else begin
                                n_word   = i_top;
                                n_status = STAT_OK;
                                op       = SH_POP;
                                n_fill   = r_fill - ONE;
                            end
                        end
                        CMD_DISPLAY: begin
                            if (r_fill == '0) begin
                                n_out_valid = 1'b1;
                                n_word      = EMPTY_WORD;
                                n_status    = STAT_EMPTY;
                                n_last      = 1'b1;
                            end else begin
                                n_left = r_fill;
                            end
                        end
                        default: op = SH_HOLD;
                    endcase
                end
            end
            ST_DUMP: begin
                // emit the top, then rotate the occupied cells up by one
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_word      = i_top;
                    n_status    = STAT_OK;
                    n_last      = (r_left == ONE);
                    op          = SH_ROT;
                    n_left      = r_left - ONE;
                end
            end
            default: op = SH_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.word   = r_word;
    assign o_res.status = r_status;
    assign o_res.last   = r_last;
    assign o_op         = op;
    assign o_fill       = r_fill;

    `ASSERT_ALWAYS(a_fill_range, r_fill <= FILL_MAX, "fill count beyond depth")
    `ASSERT_ALWAYS(a_dump_blocks, (r_state == ST_DUMP) |-> !i_cmd.ready, "item taken during dump")
    `ASSERT_ALWAYS(a_dump_left, (r_state == ST_DUMP) |-> (r_left != '0), "dump with nothing left")
    `ASSERT_NEXT(a_push_grows,
        accept && i_cmd.command == CMD_PUSH && r_fill != FILL_MAX,
        r_fill == $past(r_fill) + ONE, "push did not grow the stack")
    `ASSERT_NEXT(a_dump_fill_kept, r_state == ST_DUMP, r_fill == $past(r_fill),
        "fill count moved during dump")

endmodule

// File: sv/lsd_chain.sv
// the row of storage cells, each linked to its neighbours
// depends on lsd_pkg and lsd_cell
module lsd_chain #(
    parameter int DEPTH  = 64,
    parameter int FILL_W = 7
) (
    input  logic                             i_clk,
    input  lsd_pkg::t_shift                  i_op,
    input  logic [FILL_W-1:0]                i_fill,
    input  logic signed [lsd_pkg::WORD_W-1:0] i_push,
    output logic signed [lsd_pkg::WORD_W-1:0] o_top
);
    import lsd_pkg::*;

    logic signed [WORD_W-1:0] w_word [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] w_up;
        logic signed [WORD_W-1:0] w_down;

        if (g == 0) begin : g_first
            assign w_up = i_push;
        end else begin : g_mid
            assign w_up = w_word[g-1];
        end

        // the bottom cell pulls nothing real on a pop
        if (g == DEPTH - 1) begin : g_bottom
            assign w_down = '0;
        end else begin : g_inner
            assign w_down = w_word[g+1];
        end

        lsd_cell #(
            .IDX    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (i_op),
            .i_fill (i_fill),
            .i_up   (w_up),
            .i_down (w_down),
            .i_top  (w_word[0]),
            .o_word (w_word[g])
        );
    end

    assign o_top = w_word[0];

endmodule

// File: sv/lifo_stack_with_dump.sv
// top level of the lifo stack with dump: control plus cell chain
// depends on lsd_pkg, lsd_ifs, lsd_ctrl and lsd_chain
//
//  channel  dir  payload                 handshake
//  i_cmd    in   command, push_value     valid/ready
//  o_res    out  word, status, last      valid/ready
//
// push and pop results are registered; an item can enter every cycle while
// the result register drains. a display of n words is accepted, then the
// cell chain rotates once per word as each word is emitted, and it blocks
// new items until the last word.
// reset (synchronous, active low) empties the stack; stored words keep no reset.
// a stalled result holds the chain and the next item.
module lifo_stack_with_dump #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsd_in_if.sink    i_cmd,
    lsd_out_if.source o_res
);
    import lsd_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    t_shift                   w_op;
    logic [FILL_W-1:0]        w_fill;
    logic signed [WORD_W-1:0] w_top;

    lsd_ctrl #(
        .DEPTH  (DEPTH),
        .FILL_W (FILL_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_top   (w_top),
        .o_op    (w_op),
        .o_fill  (w_fill)
    );

    lsd_chain #(
        .DEPTH  (DEPTH),
        .FILL_W (FILL_W)
    ) u_chain (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .i_fill (w_fill),
        .i_push (i_cmd.push_value),
        .o_top  (w_top)
    );

endmodule
